### sv/bmf_pkg.sv
package bmf_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Register field width of image_width and image_height
  localparam int unsigned DIM_W = 11;

  // Column index into the line memory, row counter up to height + 1
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  // One raster step on its way from the line memory read to the vote
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             pix;        // raw pixel, masked by vld_cur
    logic             vld_cur;    // current row lies in the frame
    logic             vld_above;  // row above lies in the frame
    logic             vld_above2; // row two above lies in the frame
    logic             col_zero;   // step at column zero: vote on old window only
    logic             emit;
    logic             frame_end;
  } bmf_step_t;

endpackage

### sv/bmf_in_if.sv
interface bmf_in_if;
  logic valid;
  logic ready;
  logic req_type;
  logic pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

### sv/bmf_out_if.sv
interface bmf_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end,
                output ready);
endinterface

### sv/bmf_line_mem.sv
module bmf_line_mem import bmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i,
  output logic [1:0]       rd_data_o
);

  // bit 0: pixel one row up, bit 1: pixel two rows up
  logic [1:0] mem_q [MAX_WIDTH];
  logic [1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      // bypass the write landing on the same column in this cycle
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### sv/bmf_window.sv
module bmf_window import bmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  bmf_step_t step_i,
  input  logic      above_i,
  input  logic      above2_i,
  output logic      pixel_o
);

  // Two stored columns, bit 0 current row, bit 1 above, bit 2 two above
  logic [2:0] left_ones_q, left_vld_q, mid_ones_q, mid_vld_q;
  logic [2:0] cur_ones, cur_vld;
  logic [8:0] all_ones, all_vld;
  logic [3:0] n_ones, n_size;

  function automatic logic [3:0] popcount9(input logic [8:0] v);
    logic [3:0] acc;
    acc = 4'd0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + {3'd0, v[i]};
    end
    return acc;
  endfunction

  assign cur_vld  = {step_i.vld_above2, step_i.vld_above, step_i.vld_cur};
  assign cur_ones = {above2_i, above_i, step_i.pix} & cur_vld;

  // At column zero the vote is for the previous row's last pixel: no right column
  assign all_ones = {left_ones_q, mid_ones_q, step_i.col_zero ? 3'b000 : cur_ones};
  assign all_vld  = {left_vld_q, mid_vld_q, step_i.col_zero ? 3'b000 : cur_vld};

  assign n_ones = popcount9(all_ones);
  assign n_size = popcount9(all_vld);

  // one exactly when zeros <= size / 2
  assign pixel_o = ({1'b0, n_size} <= {n_ones, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_vld_q  <= 3'b000;
      left_ones_q <= 3'b000;
      mid_vld_q   <= 3'b000;
      mid_ones_q  <= 3'b000;
    end else if (adv_i) begin
      if (step_i.col_zero) begin
        // drop the previous row's columns off the left edge
        left_vld_q  <= 3'b000;
        left_ones_q <= 3'b000;
      end else begin
        left_vld_q  <= mid_vld_q;
        left_ones_q <= mid_ones_q;
      end
      mid_vld_q  <= cur_vld;
      mid_ones_q <= cur_ones;
    end
  end

endmodule

### sv/binary_median_filter_3x3_top.sv
// Channel  | Dir | Fields                          | Handshake
// item_i   | in  | req_type, pixel_in              | valid/ready
// result_o | out | pixel_out, row_end, frame_end   | valid/ready
// cfg      | in  | cfg_idx_i, cfg_wdata_i          | cfg_we_i, no wait
//
// One item per cycle unless the result stalls; the result for a pixel leaves when
// the pixel one row plus one column later is taken, via the line memory read,
// then the vote into the output register. A frame of height one takes a step
// with no item, ready low, when its last pixel is in. Reset needs no memory pass.
// A stalled result holds the vote stage; one more item is still taken behind it.
module binary_median_filter_3x3_top import bmf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bmf_in_if.sink               item_i,
  bmf_out_if.source            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i
);

  logic [DIM_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d, last_col;
  logic [ROW_W-1:0] row_q, row_d, h_row, h_row1;

  logic      real_phase, fill_step, slot_free, take, step;
  logic      s1_valid_q, s1_adv;
  bmf_step_t s1_q, s1_d;

  logic [1:0] rd_data;
  logic       vote;

  logic out_valid_q, pixel_out_q, row_end_q, frame_end_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign h_row    = ROW_W'(height_q);
  assign h_row1   = h_row + ROW_W'(1);
  assign last_col = COL_W'(width_q - DIM_W'(1));

  // Rows at or past height are flush rows: every item advances the scan
  assign real_phase = (row_q < h_row);
  // Height one: row one, column zero yields no result, so take it without an item
  assign fill_step  = (height_q == DIM_W'(1)) && (row_q == ROW_W'(1)) && (col_q == '0);

  assign s1_adv    = s1_valid_q && (!s1_q.emit || !out_valid_q || result_o.ready);
  assign slot_free = !s1_valid_q || s1_adv;

  assign item_i.ready = slot_free && !fill_step;
  assign take = item_i.valid && item_i.ready;
  assign step = slot_free &&
                (fill_step || (take && (!real_phase || (item_i.req_type == REQ_PIXEL))));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_q == h_row1) begin
      col_d = '0;
      row_d = '0;
    end else if (col_q == last_col) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  always_comb begin
    s1_d.col        = col_q;
    s1_d.pix        = item_i.pixel_in;
    s1_d.vld_cur    = (row_q < h_row);
    s1_d.vld_above  = (row_q != '0) && (row_q <= h_row);
    s1_d.vld_above2 = (row_q >= ROW_W'(2)) && (row_q <= h_row1);
    s1_d.col_zero   = (col_q == '0);
    s1_d.emit       = (col_q == '0) ? (row_q >= ROW_W'(2)) : (row_q != '0);
    s1_d.frame_end  = (col_q == '0) && (row_q == h_row1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      // any write restarts the frame
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_wdata_i, DIM_W'(MAX_WIDTH));
        CFG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_wdata_i, DIM_W'(MAX_HEIGHT));
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (step) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (step) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_q <= s1_d;
    end
  end

  // Entry of a column shifts down one row as each new pixel of that column passes
  bmf_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (step),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_q.col),
    .wr_data_i ({rd_data[0], s1_q.pix}),
    .rd_data_o (rd_data)
  );

  bmf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .step_i   (s1_q),
    .above_i  (rd_data[0]),
    .above2_i (rd_data[1]),
    .pixel_o  (vote)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      pixel_out_q <= vote;
      row_end_q   <= s1_q.col_zero;
      frame_end_q <= s1_q.frame_end;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pixel_out = pixel_out_q;
  assign result_o.row_end   = row_end_q;
  assign result_o.frame_end = frame_end_q;

endmodule
